@@ rtl/core/gsig_pkg.sv @@
// Package for the grid strip index generator: field widths, parameter
// defaults, configuration register indexes and the strip phase type.
// Used by the channel interfaces and the top level; depends on nothing.
`default_nettype none

package gsig_pkg;

    // Fixed field widths of the channels.
    localparam int CFG_W         = 11;
    localparam int IDX_W         = 20;
    localparam int CFG_ADDR_W    = 2;

    // Defaults for the grid size limits.
    localparam int MAX_ROW_LENGTH_DEF = 1024;
    localparam int MAX_ROW_COUNT_DEF  = 1024;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_LENGTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_COUNT  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WRAP_ROWS  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] ROW_LENGTH_RST = 11'd2;
    localparam logic [CFG_W-1:0] ROW_COUNT_RST  = 11'd2;

    // Position inside one column step or band join of the strip.
    typedef enum logic [1:0] {
        PH_CUR  = 2'd0,
        PH_NXT  = 2'd1,
        PH_DEG0 = 2'd2,
        PH_DEG1 = 2'd3
    } t_phase;

endpackage

`default_nettype wire

@@ rtl/core/gsig_if.sv @@
// Channel interfaces of the grid strip index generator: request beats,
// index beats and configuration write beats. Depends on gsig_pkg.
`default_nettype none

interface gsig_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface gsig_out_if;
    logic                      valid;
    logic                      ready;
    logic [gsig_pkg::IDX_W-1:0] vertex_index;
    logic                      is_degenerate;
    logic                      is_last;

    modport source (output valid, output vertex_index, output is_degenerate,
                    output is_last, input ready);
    modport sink   (input valid, input vertex_index, input is_degenerate,
                    input is_last, output ready);
endinterface

interface gsig_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [gsig_pkg::CFG_ADDR_W-1:0] index;
    logic [gsig_pkg::CFG_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/grid_strip_index_generator_unit.sv @@
// Grid triangle strip index generator, top level.
// Depends on gsig_pkg and the channel interfaces in gsig_if.sv.
//
// Usage:
//   i_in carries one request beat per index: restart=1 begins a new strip
//   and yields its first index, restart=0 yields the next index. After the
//   last index of the strip, a plain advance begins the strip again.
//   o_out carries one index beat per request, with flags for the two
//   band-joining degenerate indices and for the final index of the strip.
//   i_cfg writes row_length (0), row_count (1) and wrap_rows (2); it is
//   always ready, and writes to other indexes are dropped. Write it only
//   while no request is in flight.
// Timing:
//   An accepted beat passes the middle stage and the output register to o_out.
//   One beat per cycle is sustained while o_out is ready: the strip counters step
//   in the accept cycle, the row-base multiply and column add in the next stage.
// Reset:
//   Configuration returns to a 2 x 2 plain grid and the strip position to
//   its first index. Both pipeline stages empty.
// Stall:
//   When o_out is not ready, the output register holds its beat; the
//   middle stage still fills once, then i_in.ready drops.
`default_nettype none

module grid_strip_index_generator_unit #(
    parameter int MAX_ROW_LENGTH = gsig_pkg::MAX_ROW_LENGTH_DEF,
    parameter int MAX_ROW_COUNT  = gsig_pkg::MAX_ROW_COUNT_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    gsig_in_if.sink      i_in,
    gsig_out_if.source   o_out,
    gsig_cfg_if.sink     i_cfg
);

    localparam int LEN_W  = $clog2(MAX_ROW_LENGTH + 1);
    localparam int ROW_W  = $clog2(MAX_ROW_COUNT + 1);
    localparam int CL_W   = (LEN_W > gsig_pkg::CFG_W) ? LEN_W : gsig_pkg::CFG_W;
    localparam int CR_W   = (ROW_W > gsig_pkg::CFG_W) ? ROW_W : gsig_pkg::CFG_W;
    localparam int PROD_W = LEN_W + ROW_W + 1;
    localparam int SUM_W  = (PROD_W > gsig_pkg::IDX_W) ? PROD_W : gsig_pkg::IDX_W;

    localparam logic [CL_W-1:0] LEN_MAX = CL_W'(MAX_ROW_LENGTH);
    localparam logic [CR_W-1:0] ROW_MAX = CR_W'(MAX_ROW_COUNT);

    // Middle stage: which row, what to add to its base, and the flags.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [LEN_W-1:0] offset;
        logic             deg;
        logic             last;
    } t_s1;

    // Configuration registers.
    logic [gsig_pkg::CFG_W-1:0] r_row_length;
    logic [gsig_pkg::CFG_W-1:0] r_row_count;
    logic                       r_wrap_rows;

    // Strip position.
    gsig_pkg::t_phase r_phase, n_phase;
    logic [ROW_W-1:0] r_band, n_band;
    logic [LEN_W-1:0] r_col, n_col;

    // Pipeline registers.
    logic                       r_s1_valid;
    t_s1                        r_s1, n_s1;
    logic                       r_o_valid;
    logic [gsig_pkg::IDX_W-1:0] r_o_index;
    logic                       r_o_deg;
    logic                       r_o_last;

    // Handshake and working values.
    logic             out_free;
    logic             s1_move;
    logic             in_acc;
    logic [CL_W-1:0]  len_ext;
    logic [CR_W-1:0]  rows_ext;
    logic [LEN_W-1:0] len;
    logic [ROW_W-1:0] rows;
    logic [ROW_W-1:0] bands;
    logic [ROW_W-1:0] last_band_idx;
    logic [LEN_W-1:0] last_col;
    gsig_pkg::t_phase cur_phase;
    logic [ROW_W-1:0] cur_band;
    logic [LEN_W-1:0] cur_col;
    logic [ROW_W-1:0] band;
    logic [LEN_W-1:0] col;
    logic             last_band;
    logic [ROW_W:0]   band_inc;
    logic [ROW_W-1:0] next_row;
    logic [ROW_W:0]   next_inc;
    logic [ROW_W-1:0] after_row;
    logic [SUM_W-1:0] idx_sum;

    // Configuration writes are taken in every cycle.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= gsig_pkg::ROW_LENGTH_RST;
            r_row_count  <= gsig_pkg::ROW_COUNT_RST;
            r_wrap_rows  <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                gsig_pkg::REG_ROW_LENGTH: r_row_length <= i_cfg.data;
                gsig_pkg::REG_ROW_COUNT:  r_row_count  <= i_cfg.data;
                gsig_pkg::REG_WRAP_ROWS:  r_wrap_rows  <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Pipeline flow: the output register frees when taken, and the middle
    // stage moves whenever the output register can take it.
    assign out_free   = !r_o_valid || o_out.ready;
    assign s1_move    = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;
    assign in_acc     = i_in.valid && i_in.ready;

    // Grid size, clamped to 2 .. maximum.
    always_comb begin
        len_ext  = CL_W'(r_row_length);
        rows_ext = CR_W'(r_row_count);
        if (len_ext < CL_W'(2)) begin
            len_ext = CL_W'(2);
        end else if (len_ext > LEN_MAX) begin
            len_ext = LEN_MAX;
        end
        if (rows_ext < CR_W'(2)) begin
            rows_ext = CR_W'(2);
        end else if (rows_ext > ROW_MAX) begin
            rows_ext = ROW_MAX;
        end
    end

    assign len           = len_ext[LEN_W-1:0];
    assign rows          = rows_ext[ROW_W-1:0];
    assign bands         = r_wrap_rows ? rows : rows - ROW_W'(1);
    assign last_band_idx = bands - ROW_W'(1);
    assign last_col      = len - LEN_W'(1);

    // A restart puts the strip back at its first index for this beat.
    assign cur_phase = i_in.restart ? gsig_pkg::PH_CUR : r_phase;
    assign cur_band  = i_in.restart ? '0 : r_band;
    assign cur_col   = i_in.restart ? '0 : r_col;

    // Position clamped to the grid, and the rows that follow the band.
    assign band      = (cur_band >= last_band_idx) ? last_band_idx : cur_band;
    assign col       = (cur_col >= last_col) ? last_col : cur_col;
    assign last_band = (band == last_band_idx);
    assign band_inc  = {1'b0, band} + (ROW_W + 1)'(1);
    assign next_row  = (band_inc >= {1'b0, rows}) ? '0 : band_inc[ROW_W-1:0];
    assign next_inc  = {1'b0, next_row} + (ROW_W + 1)'(1);
    assign after_row = (next_inc >= {1'b0, rows}) ? '0 : next_inc[ROW_W-1:0];

    // Next strip position.
    always_comb begin
        n_phase = cur_phase;
        n_band  = cur_band;
        n_col   = cur_col;
        case (cur_phase)
            gsig_pkg::PH_CUR: begin
                n_col   = col;
                n_phase = gsig_pkg::PH_NXT;
            end
            gsig_pkg::PH_NXT: begin
                if (col < last_col) begin
                    n_col   = col + LEN_W'(1);
                    n_phase = gsig_pkg::PH_CUR;
                end else if (last_band) begin
                    n_band  = '0;
                    n_col   = '0;
                    n_phase = gsig_pkg::PH_CUR;
                end else begin
                    n_band  = band;
                    n_col   = col;
                    n_phase = gsig_pkg::PH_DEG0;
                end
            end
            gsig_pkg::PH_DEG0: begin
                n_phase = gsig_pkg::PH_DEG1;
            end
            gsig_pkg::PH_DEG1: begin
                n_band  = last_band ? '0 : band + ROW_W'(1);
                n_col   = '0;
                n_phase = gsig_pkg::PH_CUR;
            end
            default: begin
                n_phase = gsig_pkg::PH_CUR;
            end
        endcase
    end

    // What this beat emits: a row, an offset into it, and the flags.
    always_comb begin
        n_s1 = '0;
        case (cur_phase)
            gsig_pkg::PH_CUR: begin
                n_s1.row    = band;
                n_s1.offset = col;
            end
            gsig_pkg::PH_NXT: begin
                n_s1.row    = next_row;
                n_s1.offset = col;
                n_s1.last   = (col >= last_col) && last_band;
            end
            gsig_pkg::PH_DEG0: begin
                n_s1.row    = next_row;
                n_s1.offset = last_col;
                n_s1.deg    = 1'b1;
            end
            gsig_pkg::PH_DEG1: begin
                n_s1.row    = after_row;
                n_s1.offset = '0;
                n_s1.deg    = 1'b1;
            end
            default: begin
                n_s1 = '0;
            end
        endcase
    end

    // Strip position and middle stage update on each accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= gsig_pkg::PH_CUR;
            r_band     <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase <= n_phase;
                r_band  <= n_band;
                r_col   <= n_col;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
    end

    // Row base times row length plus offset; low index bits are kept.
    assign idx_sum = SUM_W'(r_s1.row) * SUM_W'(len) + SUM_W'(r_s1.offset);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_o_index <= idx_sum[gsig_pkg::IDX_W-1:0];
            r_o_deg   <= r_s1.deg;
            r_o_last  <= r_s1.last;
        end
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.vertex_index  = r_o_index;
    assign o_out.is_degenerate = r_o_deg;
    assign o_out.is_last       = r_o_last;

    // A band-joining index is never the end of the strip.
    a_deg_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> !(r_o_deg && r_o_last))
        else $error("degenerate index flagged as last");

    // A restart beat always enters the middle stage as row 0, column 0.
    a_restart_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.restart) |=>
            (r_s1_valid && r_s1.row == '0 && r_s1.offset == '0 && !r_s1.deg))
        else $error("restart did not yield the first index");

    // The second degenerate index always follows the first one.
    a_deg_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_in.restart && r_phase == gsig_pkg::PH_DEG0) |=>
            (r_phase == gsig_pkg::PH_DEG1))
        else $error("band join left half done");

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for grid_strip_index_generator_unit.
// Depends on gsig_pkg and the channel interfaces in gsig_if.sv; predicts every
// index beat of the strip walk and compares it with what the block emits.

module tb;

    import gsig_pkg::*;

    localparam int                    POS_W         = 10;
    localparam int                    QUIET_LIMIT   = 3000;
    localparam int                    STRIP_TARGET  = 1550;
    localparam int                    HOLD_CYCLES   = 150;
    localparam int                    SETTLE_CYCLES = 8;
    // Index that no register answers to; writes there are dropped.
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE     = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0] vertex_index;
        logic             is_degenerate;
        logic             is_last;
    } strip_beat_t;

    logic i_clk;
    logic i_rst_n;

    gsig_in_if  req_if ();
    gsig_out_if idx_if ();
    gsig_cfg_if cfg_if ();

    grid_strip_index_generator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (idx_if),
        .i_cfg   (cfg_if)
    );

    // Predicted grid settings and strip position, as the block holds them.
    logic [CFG_W-1:0] grid_row_length = ROW_LENGTH_RST;
    logic [CFG_W-1:0] grid_row_count  = ROW_COUNT_RST;
    logic             grid_wrap       = 1'b0;
    logic [POS_W-1:0] walk_band       = '0;
    logic [POS_W-1:0] walk_col        = '0;
    t_phase           walk_phase      = PH_CUR;

    strip_beat_t pending_indices[$];
    int          mismatches    = 0;
    int          requests_sent = 0;
    int          quiet_cycles  = 0;
    int          hold_request  = 0;
    bit          no_idle       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sizes below 2 act as 2, sizes above the limit act as the limit.
    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v,
                                               input int unsigned maxv);
        if (v < 2) return 2;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int unsigned following_row(input int unsigned r,
                                                  input int unsigned rows);
        return (r + 1 >= rows) ? 0 : r + 1;
    endfunction

    // Steps the predicted strip walk by one request and returns its index beat.
    function automatic strip_beat_t advance_strip(input logic restart);
        int unsigned len, rows, bands, last_col, band, col, nrow, idx;
        bit          last_band;
        strip_beat_t beat;
        beat = '0;
        idx  = 0;
        if (restart) begin
            walk_band  = '0;
            walk_col   = '0;
            walk_phase = PH_CUR;
        end
        len       = clamp_size(grid_row_length, MAX_ROW_LENGTH_DEF);
        rows      = clamp_size(grid_row_count, MAX_ROW_COUNT_DEF);
        bands     = grid_wrap ? rows : rows - 1;
        last_col  = len - 1;
        // A position left beyond a shrunken grid acts as the last band or column.
        band      = (walk_band >= bands - 1) ? bands - 1 : walk_band;
        last_band = (band == bands - 1);
        col       = (walk_col >= last_col) ? last_col : walk_col;
        nrow      = following_row(band, rows);
        case (walk_phase)
            PH_CUR: begin
                idx        = band * len + col;
                walk_col   = POS_W'(col);
                walk_phase = PH_NXT;
            end
            PH_NXT: begin
                idx = nrow * len + col;
                if (col < last_col) begin
                    walk_col   = POS_W'(col + 1);
                    walk_phase = PH_CUR;
                end else if (last_band) begin
                    beat.is_last = 1'b1;
                    walk_band    = '0;
                    walk_col     = '0;
                    walk_phase   = PH_CUR;
                end else begin
                    walk_band  = POS_W'(band);
                    walk_col   = POS_W'(col);
                    walk_phase = PH_DEG0;
                end
            end
            PH_DEG0: begin
                idx                = nrow * len + last_col;
                beat.is_degenerate = 1'b1;
                walk_phase         = PH_DEG1;
            end
            default: begin
                idx                = following_row(nrow, rows) * len;
                beat.is_degenerate = 1'b1;
                walk_band          = last_band ? '0 : POS_W'(band + 1);
                walk_col           = '0;
                walk_phase         = PH_CUR;
            end
        endcase
        beat.vertex_index = idx[IDX_W-1:0];
        return beat;
    endfunction

    // Mostly back-to-back, sometimes a short pause, rarely a long one.
    function automatic int idle_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Grid sizes: mostly small, a few mid-sized, a few at, near or past the limits.
    function automatic logic [CFG_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 82) return CFG_W'($urandom_range(2, 7));
        if (r < 92) return CFG_W'($urandom_range(8, 40));
        if (r < 97) begin
            case ($urandom_range(0, 5))
                0:       return CFG_W'(0);
                1:       return CFG_W'(1);
                2:       return CFG_W'(1023);
                3:       return CFG_W'(1024);
                4:       return CFG_W'(1025);
                default: return CFG_W'(2047);
            endcase
        end
        return CFG_W'($urandom_range(0, 2047));
    endfunction

    // Index beat receiver: random stalls plus an occasional long hold-off.
    initial begin : index_sink
        int hold_left;
        int stall_left;
        hold_left    = 0;
        stall_left   = 0;
        idx_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                idx_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                idx_if.ready <= 1'b0;
            end else begin
                idx_if.ready <= 1'b1;
                stall_left = idle_gap();
            end
        end
    end

    // Register writes update the prediction, index beats are checked against
    // the oldest expectation, and each accepted request adds one expectation.
    always @(posedge i_clk) begin : beat_monitor
        strip_beat_t want;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    REG_ROW_LENGTH: grid_row_length = cfg_if.data;
                    REG_ROW_COUNT:  grid_row_count  = cfg_if.data;
                    REG_WRAP_ROWS:  grid_wrap       = cfg_if.data[0];
                    default: ;
                endcase
            end
            if (idx_if.valid && idx_if.ready) begin
                if (pending_indices.size() == 0) begin
                    $error("index beat %0d with nothing expected", idx_if.vertex_index);
                    mismatches++;
                end else begin
                    want = pending_indices.pop_front();
                    if (idx_if.vertex_index !== want.vertex_index) begin
                        $error("vertex_index expected %0d, got %0d",
                               want.vertex_index, idx_if.vertex_index);
                        mismatches++;
                    end
                    if (idx_if.is_degenerate !== want.is_degenerate) begin
                        $error("is_degenerate expected %0b, got %0b",
                               want.is_degenerate, idx_if.is_degenerate);
                        mismatches++;
                    end
                    if (idx_if.is_last !== want.is_last) begin
                        $error("is_last expected %0b, got %0b",
                               want.is_last, idx_if.is_last);
                        mismatches++;
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                pending_indices.push_back(advance_strip(req_if.restart));
            end
        end
    end

    // Ends the run when no beat of any kind moves for too long.
    always @(posedge i_clk) begin : watchdog
        if ((req_if.valid && req_if.ready) || (idx_if.valid && idx_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offers one request beat and returns at the falling edge after acceptance.
    task automatic send_request(input logic restart);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.restart <= restart;
        do @(posedge i_clk); while (!req_if.ready);
        requests_sent++;
        @(negedge i_clk);
    endtask

    // Stops requests and waits until every predicted index has come back.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (pending_indices.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] index,
                                  input logic [CFG_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Reset grid: the whole 2 x 2 strip, the advance past its end, a restart.
    task automatic test_default_strip();
        repeat (6) send_request(1'b0);
        send_request(1'b1);
    endtask

    // Sizes below 2 and above the limit, a write to the spare index, and a
    // wrap value carried with junk in its upper bits.
    task automatic test_clamped_sizes();
        wait_drained();
        write_register(REG_ROW_LENGTH, CFG_W'(0));
        write_register(REG_ROW_COUNT, CFG_W'(1));
        send_request(1'b1);
        repeat (2) send_request(1'b0);
        wait_drained();
        write_register(REG_ROW_LENGTH, CFG_W'(2047));
        write_register(REG_ROW_COUNT, CFG_W'(2047));
        write_register(REG_WRAP_ROWS, CFG_W'(11'h7FF));
        write_register(REG_SPARE, CFG_W'(11'h555));
        send_request(1'b1);
        repeat (3) send_request(1'b0);
    endtask

    // Shrinks the grid under a strip in progress, then walks a wrapped
    // 2 x 2 torus across its band join and past its last index.
    task automatic test_wrapped_strip();
        wait_drained();
        write_register(REG_ROW_LENGTH, CFG_W'(2));
        write_register(REG_ROW_COUNT, CFG_W'(2));
        write_register(REG_WRAP_ROWS, CFG_W'(11'h401));
        repeat (11) send_request(1'b0);
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_output_hold();
        wait_drained();
        write_register(REG_ROW_LENGTH, CFG_W'(3));
        write_register(REG_ROW_COUNT, CFG_W'(4));
        write_register(REG_WRAP_ROWS, CFG_W'(0));
        no_idle      = 1'b1;
        hold_request = HOLD_CYCLES;
        send_request(1'b1);
        repeat (29) send_request(1'b0);
        no_idle = 1'b0;
    endtask

    // Phases of random grid settings, each walking a stretch of the strip
    // with rare restarts; the position carries over from phase to phase.
    task automatic test_random_strips();
        int walk_len;
        while (requests_sent < STRIP_TARGET) begin
            wait_drained();
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 7) write_register(REG_ROW_LENGTH, pick_size());
            if ($urandom_range(0, 9) < 7) write_register(REG_ROW_COUNT, pick_size());
            if ($urandom_range(0, 9) < 4) begin
                write_register(REG_WRAP_ROWS, CFG_W'($urandom_range(0, 2047)));
            end
            if ($urandom_range(0, 11) == 0) begin
                write_register(REG_SPARE, CFG_W'($urandom_range(0, 2047)));
            end
            walk_len = $urandom_range(5, 80);
            repeat (walk_len) send_request($urandom_range(0, 24) == 0);
        end
        no_idle = 1'b0;
    endtask

    initial begin : run
        req_if.valid   = 1'b0;
        req_if.restart = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = REG_ROW_LENGTH;
        cfg_if.data    = '0;
        i_rst_n        = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_default_strip();
        test_clamped_sizes();
        test_wrapped_strip();
        test_output_hold();
        test_random_strips();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
